// ----- rtl/column_running_statistics_core_assert.svh -----
// Assertion helpers shared by the statistics core modules.
// Both expect clk and rst_n in the scope where they are used.
`ifndef COLUMN_RUNNING_STATISTICS_CORE_ASSERT_SVH
`define COLUMN_RUNNING_STATISTICS_CORE_ASSERT_SVH

// Same-cycle implication
`define CRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("column statistics: assertion failed");

// Next-cycle implication
`define CRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("column statistics: assertion failed");

`endif

// ----- rtl/crs_pkg.sv -----
package crs_pkg;

  // Defaults for the top level parameters
  localparam int COLUMNS_DEF    = 8;
  localparam int VALUE_BITS_DEF = 32;

  // num_columns after reset
  localparam logic [3:0] NUM_COLUMNS_RESET = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_ROW_OK    = 2'd0;
  localparam logic [1:0] ST_ROW_BAD   = 2'd1;
  localparam logic [1:0] ST_QUERY_OK  = 2'd2;
  localparam logic [1:0] ST_QUERY_BAD = 2'd3;

  // Request commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] value;
    logic              row_last;
    logic [3:0]        column;
  } in_data_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic signed [31:0] mean_value;
    logic [31:0]        rows_seen;
  } out_data_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // request accepted this cycle
    logic start;   // fetch column operands, launch divide
    logic commit;  // write back column statistics
    logic emit;    // move pending result to output register
  } crs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic row_end;
    logic row_reject;
    logic last_col;
    logic div_done;
    logic out_free;
  } crs_status_t;

endpackage

// ----- rtl/crs_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module crs_div #(
  parameter int VALUE_BITS = crs_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [31:0]           divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic                  done,
  output logic                  busy
);

  localparam int CNTW = $clog2(VALUE_BITS);

  logic [31:0]           rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [31:0]           div_r;
  logic [CNTW-1:0]       cnt_r;
  logic                  busy_r, done_r;
  logic [32:0]           trial;
  logic                  fits;

  // One shift-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[VALUE_BITS-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? 32'(trial - {1'b0, div_r}) : trial[31:0];
    quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(VALUE_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;
  assign busy     = busy_r;

`include "column_running_statistics_core_assert.svh"
  `CRS_ASSERT_IMPL(a_no_restart, start, !busy_r)
  `CRS_ASSERT_NEXT(a_start_busy, start, busy_r)

endmodule

// ----- rtl/crs_datapath.sv -----
// Row buffer, per-column statistics, row bookkeeping and result registers.
module crs_datapath #(
  parameter int COLUMNS    = crs_pkg::COLUMNS_DEF,
  parameter int VALUE_BITS = crs_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crs_pkg::crs_cmd_t   cmd_i,
  output crs_pkg::crs_status_t status_o,
  input  crs_pkg::in_data_t   in_data,
  input  logic                cfg_valid,
  input  logic [3:0]          cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output crs_pkg::out_data_t  out_data
);

  localparam int VB   = VALUE_BITS;
  localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PW   = $clog2(COLUMNS + 1);
  localparam int CMPW = (PW > 4) ? PW : 4;

  logic [VB-1:0] buf_r  [COLUMNS];
  logic [VB-1:0] min_r  [COLUMNS];
  logic [VB-1:0] max_r  [COLUMNS];
  logic [VB-1:0] mean_r [COLUMNS];

  logic [3:0]    num_columns_r;
  logic [PW-1:0] pos_r;
  logic [31:0]   row_count_r;
  logic          first_r;
  logic [CW-1:0] col_r;

  logic [VB-1:0] x_r, m_r;
  logic          ge_r;

  crs_pkg::out_data_t res_r;
  crs_pkg::out_data_t out_data_r;
  logic               out_valid_r;

  // Incoming value and row length checks
  logic [VB-1:0]  in_x;
  logic           overflow;
  logic [PW-1:0]  length;
  logic           reject;
  logic           in_range;

  assign in_x     = VB'($unsigned(in_data.value));
  assign overflow = pos_r >= PW'(COLUMNS);
  assign length   = overflow ? pos_r : pos_r + PW'(1);
  assign reject   = overflow || (CMPW'(length) != CMPW'(num_columns_r));
  assign in_range = (CMPW'(in_data.column) < CMPW'(num_columns_r)) &&
                    (CMPW'(in_data.column) < CMPW'(COLUMNS));

  // Shared statistics read port: query column on a request, else loop column
  logic [CW-1:0] rd_idx;
  logic [VB-1:0] min_rd, max_rd, mean_rd, buf_rd;

  assign rd_idx  = cmd_i.take ? in_data.column[CW-1:0] : col_r;
  assign min_rd  = min_r[rd_idx];
  assign max_rd  = max_r[rd_idx];
  assign mean_rd = mean_r[rd_idx];
  assign buf_rd  = buf_r[col_r];

  // Mean update operands
  logic          ge;
  logic [VB-1:0] mag;
  logic [VB-1:0] quo;
  logic          div_done;
  logic          div_busy;
  logic [VB-1:0] mean_new;

  assign ge       = $signed(buf_rd) >= $signed(mean_rd);
  assign mag      = ge ? buf_rd - mean_rd : mean_rd - buf_rd;
  assign mean_new = ge_r ? m_r + quo : m_r - quo;

  crs_div #(
    .VALUE_BITS(VB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.start),
    .dividend (mag),
    .divisor  (row_count_r),
    .quotient (quo),
    .done     (div_done),
    .busy     (div_busy)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_columns_r <= crs_pkg::NUM_COLUMNS_RESET;
    end else if (cfg_valid) begin
      num_columns_r <= cfg_data;
    end
  end

  // Row position, row count and column loop counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      row_count_r <= '0;
      first_r     <= 1'b0;
      col_r       <= '0;
    end else if (cmd_i.take && in_data.cmd == crs_pkg::CMD_PUSH) begin
      if (in_data.row_last) begin
        pos_r <= '0;
        if (!reject) begin
          first_r <= row_count_r == '0;
          col_r   <= '0;
          if (row_count_r != '1) begin
            row_count_r <= row_count_r + 32'd1;
          end
        end
      end else if (!overflow) begin
        pos_r <= pos_r + PW'(1);
      end
    end else if (cmd_i.commit) begin
      col_r <= col_r + CW'(1);
    end
  end

  // Row buffer
  always_ff @(posedge clk) begin
    if (cmd_i.take && in_data.cmd == crs_pkg::CMD_PUSH && !overflow) begin
      buf_r[pos_r[CW-1:0]] <= in_x;
    end
  end

  // Column statistics, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        min_r[i]  <= '0;
        max_r[i]  <= '0;
        mean_r[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      mean_r[col_r] <= mean_new;
      if (first_r) begin
        min_r[col_r] <= x_r;
        max_r[col_r] <= x_r;
      end else if ($signed(x_r) < $signed(min_rd)) begin
        min_r[col_r] <= x_r;
      end else if ($signed(x_r) > $signed(max_rd)) begin
        max_r[col_r] <= x_r;
      end
    end
  end

  // Operands held across the divide
  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      x_r  <= buf_rd;
      m_r  <= mean_rd;
      ge_r <= ge;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      res_r.rows_seen <= row_count_r;
      if (in_data.cmd == crs_pkg::CMD_QUERY) begin
        if (in_range) begin
          res_r.status     <= crs_pkg::ST_QUERY_OK;
          res_r.min_value  <= 32'($signed(min_rd));
          res_r.max_value  <= 32'($signed(max_rd));
          res_r.mean_value <= 32'($signed(mean_rd));
        end else begin
          res_r.status     <= crs_pkg::ST_QUERY_BAD;
          res_r.min_value  <= '0;
          res_r.max_value  <= '0;
          res_r.mean_value <= '0;
        end
      end else begin
        res_r.status     <= crs_pkg::ST_ROW_BAD;
        res_r.min_value  <= '0;
        res_r.max_value  <= '0;
        res_r.mean_value <= '0;
      end
    end else if (cmd_i.commit) begin
      res_r.status    <= crs_pkg::ST_ROW_OK;
      res_r.rows_seen <= row_count_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to controller
  always_comb begin
    status_o.is_query   = in_data.cmd == crs_pkg::CMD_QUERY;
    status_o.row_end    = in_data.cmd == crs_pkg::CMD_PUSH && in_data.row_last;
    status_o.row_reject = reject;
    status_o.last_col   = CMPW'(col_r) == CMPW'(num_columns_r) - CMPW'(1);
    status_o.div_done   = div_done;
    status_o.out_free   = !out_valid_r || out_ready;
  end

`include "column_running_statistics_core_assert.svh"
  `CRS_ASSERT_IMPL(a_commit_counted, cmd_i.commit, row_count_r != '0)
  `CRS_ASSERT_IMPL(a_commit_idle_div, cmd_i.commit, !div_busy)

endmodule

// ----- rtl/crs_ctrl.sv -----
// Sequencer: takes one request, runs the column loop, hands off the result.
module crs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  crs_pkg::crs_status_t status_i,
  output crs_pkg::crs_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign in_ready = state_r == S_IDLE;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd_o.take   = take;
    cmd_o.start  = state_r == S_LOAD;
    cmd_o.commit = state_r == S_WRITE;
    cmd_o.emit   = state_r == S_EMIT && status_i.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (status_i.is_query) begin
            state_nxt = S_EMIT;
          end else if (status_i.row_end) begin
            state_nxt = status_i.row_reject ? S_EMIT : S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = status_i.last_col ? S_EMIT : S_LOAD;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "column_running_statistics_core_assert.svh"
  `CRS_ASSERT_IMPL(a_done_in_div, status_i.div_done, state_r == S_DIV)
  `CRS_ASSERT_NEXT(a_emit_to_idle, cmd_o.emit, state_r == S_IDLE)

endmodule

// ----- rtl/column_running_statistics_core.sv -----
// Running min / max / mean per column over rows streamed one value at a time.
// Input channel (in_valid/in_ready/in_data): a push request stores one value;
// the value flagged row_last closes the row. A query request reads the
// statistics of one column. Each row end and each query gives one result on
// the output channel (out_valid/out_ready/out_data); a push without row_last
// gives none. cfg_valid/cfg_ready/cfg_data writes num_columns, always ready.
// A push without row_last leaves the block ready for another request. A
// query or a rejected row goes straight to the emit step and shows its result
// once the output register is free. An accepted row runs one column at a time
// through a bit-per-cycle divider, each column in the steps load, divide and
// write, and then emits its result. The next request is taken once that work
// ends, also while the result still waits in the output register. A stalled
// receiver holds the output register; a second result then waits in the block
// and no request is taken until the first is gone.
// Reset (rst_n low, synchronous) clears the row position, row count and all
// column statistics and sets num_columns to 8.
module column_running_statistics_core #(
  parameter int COLUMNS    = crs_pkg::COLUMNS_DEF,
  parameter int VALUE_BITS = crs_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crs_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crs_pkg::out_data_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  crs_pkg::crs_cmd_t    cmd;
  crs_pkg::crs_status_t status;

  assign cfg_ready = 1'b1;

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  crs_datapath #(
    .COLUMNS    (COLUMNS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .status_o  (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
